FILE: design/seh_pkg.sv
// seh_pkg: types, constants and helper functions of the star horizon transform
// used by seh_cordic, the top level and the port checker; no dependencies
package seh_pkg;

   localparam int ANG_W             = 16;
   localparam int Q15_W             = 16;
   localparam int MAG_W             = 12;
   localparam int COLOR_W           = 8;
   localparam int CORDIC_W          = 34;   // q2.30 data and 2^-32 turn angles, with headroom
   localparam int PROD_W            = 32;
   localparam int ATAN_ENTRIES      = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
   localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [ANG_W-1:0] HALF_TURN    = 16'h8000;
   localparam logic [ANG_W-1:0] EIGHTH_TURN  = 16'h2000;

   localparam logic [COLOR_W-1:0] COLOR_FAINT  = 8'd212;
   localparam logic [COLOR_W-1:0] COLOR_BRIGHT = 8'd219;

   // register indexes on the csr port
   localparam logic CSR_SIDEREAL = 1'b0;
   localparam logic CSR_LATITUDE = 1'b1;

   typedef struct packed {
      logic        [ANG_W-1:0] right_ascension;
      logic signed [ANG_W-1:0] declination;
      logic signed [MAG_W-1:0] magnitude;
   } req_type;

   typedef struct packed {
      logic signed [Q15_W-1:0]   vec_x;
      logic signed [Q15_W-1:0]   vec_y;
      logic signed [Q15_W-1:0]   vec_z;
      logic                      above_horizon;
      logic        [COLOR_W-1:0] color_index;
   } rsp_type;

   typedef struct packed {
      logic        [1:0]          quad;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
   } cordic_type;

   // arctan(2^-i) in 2^-32 turn
   function automatic logic signed [CORDIC_W-1:0] atan_entry(input int idx);
      logic signed [CORDIC_W-1:0] a;
      a = '0;
      unique case (idx)
         0:  a = CORDIC_W'(536870912);
         1:  a = CORDIC_W'(316933406);
         2:  a = CORDIC_W'(167458907);
         3:  a = CORDIC_W'(85004756);
         4:  a = CORDIC_W'(42667331);
         5:  a = CORDIC_W'(21354465);
         6:  a = CORDIC_W'(10679838);
         7:  a = CORDIC_W'(5340245);
         8:  a = CORDIC_W'(2670163);
         9:  a = CORDIC_W'(1335087);
         10: a = CORDIC_W'(667544);
         11: a = CORDIC_W'(333772);
         12: a = CORDIC_W'(166886);
         13: a = CORDIC_W'(83443);
         14: a = CORDIC_W'(41722);
         15: a = CORDIC_W'(20861);
         16: a = CORDIC_W'(10430);
         17: a = CORDIC_W'(5215);
         18: a = CORDIC_W'(2608);
         19: a = CORDIC_W'(1304);
         20: a = CORDIC_W'(652);
         21: a = CORDIC_W'(326);
         22: a = CORDIC_W'(163);
         23: a = CORDIC_W'(81);
         default: a = '0;
      endcase
      return a;
   endfunction

   // q2.30 to q1.15, round half up, saturate
   function automatic logic signed [Q15_W-1:0] round_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] t;
      t = (v + CORDIC_W'(16384)) >>> 15;
      if (t > CORDIC_W'(32767)) return 16'sh7fff;
      if (t < -CORDIC_W'(32768)) return 16'sh8000;
      return t[Q15_W-1:0];
   endfunction

   // palette index from magnitude, thresholds are j*0.667 in 1/256 units
   function automatic logic [COLOR_W-1:0] color_of(input logic signed [MAG_W-1:0] mag);
      logic signed [MAG_W-1:0] th [7];
      logic [COLOR_W-1:0] c;
      th[0] = 12'sd0;   th[1] = 12'sd171; th[2] = 12'sd342; th[3] = 12'sd513;
      th[4] = 12'sd684; th[5] = 12'sd854; th[6] = 12'sd1025;
      c = COLOR_FAINT;
      for (int j = 6; j >= 0; j--) begin
         if (mag < th[j]) c = COLOR_BRIGHT - COLOR_W'(j);
      end
      return c;
   endfunction

endpackage

FILE: design/star_equatorial_to_horizon_transform_unit.sv
// star_equatorial_to_horizon_transform_unit: top level of the star transform
// depends on seh_pkg and seh_cordic
//
// Turns one star (right ascension, declination, magnitude) into a horizon
// frame unit vector in q1.15, a visibility flag and a palette color. Every
// star is independent, so one transaction can enter each clock while
// req_stall is low. The stages are one entry stage, one stage per cordic
// iteration in three parallel lanes (declination, hour angle, colatitude),
// then quadrant fix and rounding, the two first products, the four rotation
// products and the final sums into the output register. Each stage keeps its
// own valid bit and a stall only holds stages that are full, so bubbles are
// squeezed out. The user must write sidereal time and latitude through the
// csr port while no transaction is in flight; the block does not enforce it.
module star_equatorial_to_horizon_transform_unit import seh_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [ANG_W-1:0] csr_wdata
);

   localparam int ST_A = CORDIC_STAGES + 1;   // quadrant fix and rounding
   localparam int ST_B = CORDIC_STAGES + 2;   // x and y products
   localparam int ST_C = CORDIC_STAGES + 3;   // rotation products
   localparam int LAST = CORDIC_STAGES + 4;   // output register

   // configuration
   logic [ANG_W-1:0] sidereal_ff;
   logic [ANG_W-1:0] latitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sidereal_ff <= '0;
         latitude_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIDEREAL: sidereal_ff <= csr_wdata;
            CSR_LATITUDE: latitude_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // per-stage valid bits and stall chain
   logic [LAST:0]   valid_ff;
   logic [LAST+1:0] ready;

   always_comb begin
      ready[LAST+1] = !rsp_stall;
      for (int k = LAST; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k <= LAST; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_stall = !ready[0];

   // angles of the three lanes
   logic [ANG_W-1:0] hour_angle;
   logic [ANG_W-1:0] colat_angle;

   assign hour_angle  = req_data.right_ascension - HALF_TURN - sidereal_ff;
   assign colat_angle = QUARTER_TURN - latitude_ff;

   cordic_type dec_res, hour_res, colat_res;

   seh_cordic #(.STAGES(CORDIC_STAGES)) u_dec (
      .clock   (clock),
      .advance (ready[CORDIC_STAGES:0]),
      .angle   (req_data.declination),
      .result  (dec_res)
   );

   seh_cordic #(.STAGES(CORDIC_STAGES)) u_hour (
      .clock   (clock),
      .advance (ready[CORDIC_STAGES:0]),
      .angle   (hour_angle),
      .result  (hour_res)
   );

   seh_cordic #(.STAGES(CORDIC_STAGES)) u_colat (
      .clock   (clock),
      .advance (ready[CORDIC_STAGES:0]),
      .angle   (colat_angle),
      .result  (colat_res)
   );

   // color rides alongside the cordic lanes
   logic [COLOR_W-1:0] color_ff [LAST];

   always_ff @(posedge clock) begin
      if (ready[0]) color_ff[0] <= color_of(req_data.magnitude);
      for (int k = 1; k < LAST; k++) begin
         if (ready[k]) color_ff[k] <= color_ff[k-1];
      end
   end

   // quadrant fix: returns {cos, sin} rounded to q1.15
   function automatic logic [2*Q15_W-1:0] fix_quad(input cordic_type r);
      logic signed [CORDIC_W-1:0] c, s;
      unique case (r.quad)
         2'd0: begin c = r.x;  s = r.y;  end
         2'd1: begin c = -r.y; s = r.x;  end
         2'd2: begin c = -r.x; s = -r.y; end
         default: begin c = r.y; s = -r.x; end
      endcase
      return {round_q15(c), round_q15(s)};
   endfunction

   // stage a
   logic signed [Q15_W-1:0] cd_ff, sd_ff, ch_ff, sh_ff, cc_a_ff, sc_a_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_A]) begin
         {cd_ff, sd_ff}     <= fix_quad(dec_res);
         {ch_ff, sh_ff}     <= fix_quad(hour_res);
         {cc_a_ff, sc_a_ff} <= fix_quad(colat_res);
      end
   end

   // stage b: equatorial vector
   logic signed [PROD_W-1:0] px, py;
   logic signed [Q15_W-1:0]  x_b_ff, y_b_ff, z_b_ff, cc_b_ff, sc_b_ff;

   assign px = cd_ff * ch_ff;
   assign py = cd_ff * sh_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_B]) begin
         x_b_ff  <= round_q15({{(CORDIC_W-PROD_W){px[PROD_W-1]}}, px});
         y_b_ff  <= round_q15({{(CORDIC_W-PROD_W){py[PROD_W-1]}}, py});
         z_b_ff  <= sd_ff;
         cc_b_ff <= cc_a_ff;
         sc_b_ff <= sc_a_ff;
      end
   end

   // stage c: rotation about y by the colatitude
   logic signed [PROD_W-1:0] sz_ff, cx_ff, cz_ff, sx_ff;
   logic signed [Q15_W-1:0]  y_c_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_C]) begin
         sz_ff  <= sc_b_ff * z_b_ff;
         cx_ff  <= cc_b_ff * x_b_ff;
         cz_ff  <= cc_b_ff * z_b_ff;
         sx_ff  <= sc_b_ff * x_b_ff;
         y_c_ff <= y_b_ff;
      end
   end

   // output stage
   logic signed [CORDIC_W-1:0] sum_x, sum_z;
   logic signed [Q15_W-1:0]    x2, z2;
   rsp_type                    out_ff;

   always_comb begin
      sum_x = {{(CORDIC_W-PROD_W){sz_ff[PROD_W-1]}}, sz_ff}
            + {{(CORDIC_W-PROD_W){cx_ff[PROD_W-1]}}, cx_ff};
      sum_z = {{(CORDIC_W-PROD_W){cz_ff[PROD_W-1]}}, cz_ff}
            - {{(CORDIC_W-PROD_W){sx_ff[PROD_W-1]}}, sx_ff};
      x2 = round_q15(sum_x);
      z2 = round_q15(sum_z);
   end

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         out_ff.vec_x         <= x2;
         out_ff.vec_y         <= y_c_ff;
         out_ff.vec_z         <= z2;
         out_ff.above_horizon <= (z2 > 0);
         out_ff.color_index   <= color_ff[LAST-1];
      end
   end

   assign rsp_valid = valid_ff[LAST];
   assign rsp_data  = out_ff;

endmodule

FILE: design/seh_cordic.sv
// seh_cordic: pipelined rotation-mode cordic lane, one stage per iteration
// depends on seh_pkg (widths, arctan table, cordic_type)
module seh_cordic import seh_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic [STAGES:0]   advance,
   input  logic [ANG_W-1:0]  angle,
   output cordic_type        result
);

   logic signed [CORDIC_W-1:0] x_ff [STAGES+1];
   logic signed [CORDIC_W-1:0] y_ff [STAGES+1];
   logic signed [CORDIC_W-1:0] z_ff [STAGES+1];
   logic        [1:0]          quad_ff [STAGES+1];

   logic [ANG_W-1:0] shifted;
   logic [1:0]       quad_in;
   logic [ANG_W-1:0] resid;

   // quadrant and residual within an eighth turn
   always_comb begin
      shifted = angle + EIGHTH_TURN;
      quad_in = shifted[ANG_W-1:ANG_W-2];
      resid   = angle - {quad_in, {(ANG_W-2){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= {{(CORDIC_W-ANG_W-16){resid[ANG_W-1]}}, resid, 16'b0};
         quad_ff[0] <= quad_in;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_step
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance[i+1]) begin
            quad_ff[i+1] <= quad_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
         end
      end
   end

   assign result.quad = quad_ff[STAGES];
   assign result.x    = x_ff[STAGES];
   assign result.y    = y_ff[STAGES];

endmodule

FILE: design/seh_port_checker.sv
// seh_port_checker: port-level assertions for the star transform top level
// depends on seh_pkg; bound to star_equatorial_to_horizon_transform_unit
module seh_port_checker import seh_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled rsp payload changed");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.color_index >= COLOR_FAINT)
                 && (rsp_data.color_index <= COLOR_BRIGHT))
      else $error("color index out of palette band");

   a_horizon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.above_horizon == (rsp_data.vec_z > 0))
      else $error("above_horizon disagrees with vec_z");

endmodule

bind star_equatorial_to_horizon_transform_unit seh_port_checker u_seh_port_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
